// ===== hw/rtl/wtosc_pkg.sv =====
package wtosc_pkg;

    // sizing
    localparam int TABLE_LENGTH  = 1024;
    localparam int GLIDE_SAMPLES = 256;   // power of two

    localparam int FREQ_W   = 17;
    localparam int SYMM_W   = 16;
    localparam int PPH_W    = 25;
    localparam int MODE_W   = 2;
    localparam int ROW_W    = 8;
    localparam int COL_W    = 8;
    localparam int FRAC_W   = 24;
    localparam int IDX_W    = $clog2(TABLE_LENGTH);
    localparam int PHASE_W  = IDX_W + FRAC_W;
    localparam int CNT_W    = $clog2(GLIDE_SAMPLES);
    localparam int GMC_W    = CNT_W + 1;
    localparam int MUL_A_W  = PPH_W;
    localparam int MUL_B_W  = FREQ_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ROWY_W   = 11;
    localparam int STEP_W   = 4;

    localparam int S_TDATA_W = ((MODE_W + FREQ_W + SYMM_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ROW_W + COL_W + IDX_W + 7) / 8) * 8;

    // constants
    localparam int FREQ_MIN      = 320;
    localparam int FREQ_MAX      = 81920;
    localparam int SYMM_MIN      = 328;
    localparam int SYMM_MAX      = 32768;
    localparam int FREQ_RESET    = 3600;
    localparam int SYMM_RESET    = 32768;
    localparam int PPH_RESET     = 389621;
    localparam int HZ_SHIFT      = 4;    // frequency is in 1/16 Hz
    localparam int COL_SCALE     = 255;
    localparam int COL_SHIFT     = 15;
    localparam int ROW_PRE_SHIFT = 6;    // x/320 = (x/64)/5
    localparam int ROW_RECIP     = 1639; // ~ 2^13 / 5
    localparam int ROW_SHIFT     = 13;
    localparam int ROW_MAX       = 255;
    localparam int COL_MAX       = 255;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_SET_FS = 2'd1,
        MODE_SET_F  = 2'd2
    } mode_t;

    typedef enum logic [STEP_W-1:0] {
        STEP_IDLE     = 4'd0,
        STEP_F_OLD    = 4'd1,
        STEP_F_TGT    = 4'd2,
        STEP_S_OLD    = 4'd3,
        STEP_S_TGT    = 4'd4,
        STEP_PH_MUL   = 4'd5,
        STEP_PH_ADD   = 4'd6,
        STEP_COL      = 4'd7,
        STEP_EMIT     = 4'd8,
        STEP_LOAD     = 4'd9
    } step_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_DISPATCH,
        J_HOLD_OUT,
        J_RESTART
    } jump_t;

    typedef enum logic [2:0] {
        A_F_OLD,
        A_F_TGT,
        A_S_OLD,
        A_S_TGT,
        A_PPH,
        A_S_CUR,
        A_ROWY
    } asel_t;

    typedef enum logic [2:0] {
        B_GMC,
        B_CNT,
        B_F_CUR,
        B_COL_SCALE,
        B_ROW_RECIP
    } bsel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } accop_t;

    typedef struct packed {
        jump_t  jump;
        asel_t  a_sel;
        bsel_t  b_sel;
        accop_t acc_op;
        logic   wr_freq;
        logic   wr_symm;
        logic   wr_phase;
        logic   wr_col;
        logic   wr_out;
        logic   load_pair;
    } ucode_t;

    typedef struct packed {
        logic  in_valid;
        mode_t mode;
        logic  out_free;
    } seq_status_t;

endpackage

// ===== hw/rtl/wtosc_ucode_rom.sv =====
module wtosc_ucode_rom (
    input  wtosc_pkg::step_t  step,
    output wtosc_pkg::ucode_t cw
);

    always_comb begin
        cw = '{jump: wtosc_pkg::J_RESTART, a_sel: wtosc_pkg::A_F_OLD,
               b_sel: wtosc_pkg::B_GMC, acc_op: wtosc_pkg::ACC_HOLD,
               default: 1'b0};
        case (step)
            wtosc_pkg::STEP_IDLE: begin
                cw.jump = wtosc_pkg::J_DISPATCH;
            end
            wtosc_pkg::STEP_F_OLD: begin
                cw.jump   = wtosc_pkg::J_NEXT;
                cw.a_sel  = wtosc_pkg::A_F_OLD;
                cw.b_sel  = wtosc_pkg::B_GMC;
                cw.acc_op = wtosc_pkg::ACC_LOAD;
            end
            wtosc_pkg::STEP_F_TGT: begin
                cw.jump   = wtosc_pkg::J_NEXT;
                cw.a_sel  = wtosc_pkg::A_F_TGT;
                cw.b_sel  = wtosc_pkg::B_CNT;
                cw.acc_op = wtosc_pkg::ACC_ADD;
            end
            wtosc_pkg::STEP_S_OLD: begin
                cw.jump    = wtosc_pkg::J_NEXT;
                cw.wr_freq = 1'b1;
                cw.a_sel   = wtosc_pkg::A_S_OLD;
                cw.b_sel   = wtosc_pkg::B_GMC;
                cw.acc_op  = wtosc_pkg::ACC_LOAD;
            end
            wtosc_pkg::STEP_S_TGT: begin
                cw.jump   = wtosc_pkg::J_NEXT;
                cw.a_sel  = wtosc_pkg::A_S_TGT;
                cw.b_sel  = wtosc_pkg::B_CNT;
                cw.acc_op = wtosc_pkg::ACC_ADD;
            end
            wtosc_pkg::STEP_PH_MUL: begin
                cw.jump    = wtosc_pkg::J_NEXT;
                cw.wr_symm = 1'b1;
                cw.a_sel   = wtosc_pkg::A_PPH;
                cw.b_sel   = wtosc_pkg::B_F_CUR;
                cw.acc_op  = wtosc_pkg::ACC_LOAD;
            end
            wtosc_pkg::STEP_PH_ADD: begin
                cw.jump     = wtosc_pkg::J_NEXT;
                cw.wr_phase = 1'b1;
                cw.a_sel    = wtosc_pkg::A_S_CUR;
                cw.b_sel    = wtosc_pkg::B_COL_SCALE;
                cw.acc_op   = wtosc_pkg::ACC_LOAD;
            end
            wtosc_pkg::STEP_COL: begin
                cw.jump   = wtosc_pkg::J_NEXT;
                cw.wr_col = 1'b1;
                cw.a_sel  = wtosc_pkg::A_ROWY;
                cw.b_sel  = wtosc_pkg::B_ROW_RECIP;
                cw.acc_op = wtosc_pkg::ACC_LOAD;
            end
            wtosc_pkg::STEP_EMIT: begin
                cw.jump   = wtosc_pkg::J_HOLD_OUT;
                cw.wr_out = 1'b1;
            end
            wtosc_pkg::STEP_LOAD: begin
                cw.jump      = wtosc_pkg::J_RESTART;
                cw.load_pair = 1'b1;
            end
            default: begin
                cw.jump = wtosc_pkg::J_RESTART;
            end
        endcase
    end

endmodule

// ===== hw/rtl/wtosc_seq.sv =====
module wtosc_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wtosc_pkg::seq_status_t status,
    output wtosc_pkg::ucode_t      cw,
    output logic                   in_ready
);

    wtosc_pkg::step_t step_reg;
    wtosc_pkg::step_t step_next;

    wtosc_ucode_rom u_rom (
        .step (step_reg),
        .cw   (cw)
    );

    assign in_ready = (cw.jump == wtosc_pkg::J_DISPATCH);

    always_comb begin
        step_next = step_reg;
        case (cw.jump)
            wtosc_pkg::J_NEXT: begin
                step_next = wtosc_pkg::step_t'(step_reg + 4'd1);
            end
            wtosc_pkg::J_DISPATCH: begin
                step_next = wtosc_pkg::STEP_IDLE;
                if (status.in_valid) begin
                    case (status.mode)
                        wtosc_pkg::MODE_TICK:   step_next = wtosc_pkg::STEP_F_OLD;
                        wtosc_pkg::MODE_SET_FS: step_next = wtosc_pkg::STEP_LOAD;
                        wtosc_pkg::MODE_SET_F:  step_next = wtosc_pkg::STEP_LOAD;
                        default:                step_next = wtosc_pkg::STEP_IDLE;
                    endcase
                end
            end
            wtosc_pkg::J_HOLD_OUT: begin
                if (status.out_free) begin
                    step_next = wtosc_pkg::STEP_IDLE;
                end
            end
            default: begin
                step_next = wtosc_pkg::STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= wtosc_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== hw/rtl/wtosc_datapath.sv =====
module wtosc_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wtosc_pkg::ucode_t                   cw,
    input  logic                                in_accept,
    input  wtosc_pkg::mode_t                    in_mode,
    input  logic [wtosc_pkg::FREQ_W-1:0]        in_freq,
    input  logic [wtosc_pkg::SYMM_W-1:0]        in_symm,
    input  logic                                cfg_we,
    input  logic [wtosc_pkg::PPH_W-1:0]         cfg_wdata,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [wtosc_pkg::ROW_W-1:0]         out_row,
    output logic [wtosc_pkg::COL_W-1:0]         out_col,
    output logic [wtosc_pkg::IDX_W-1:0]         out_idx,
    output logic                                out_free
);

    localparam int FW = wtosc_pkg::FREQ_W;
    localparam int SW = wtosc_pkg::SYMM_W;
    localparam int PW = wtosc_pkg::PROD_W;
    localparam int CW = wtosc_pkg::CNT_W;

    logic [FW-1:0]                 freq_a_reg, freq_b_reg, f_cur_reg;
    logic [SW-1:0]                 symm_a_reg, symm_b_reg, s_cur_reg;
    logic                          tgt_b_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [wtosc_pkg::PHASE_W-1:0] phase_reg;
    logic [wtosc_pkg::PPH_W-1:0]   pph_reg;
    logic [PW-1:0]                 acc_reg, acc_next;
    logic [wtosc_pkg::COL_W-1:0]   col_reg;
    wtosc_pkg::mode_t              mode_reg;
    logic [FW-1:0]                 nf_reg;
    logic [SW-1:0]                 ns_reg;
    logic                          out_valid_reg;
    logic [wtosc_pkg::ROW_W-1:0]   out_row_reg;
    logic [wtosc_pkg::COL_W-1:0]   out_col_reg;
    logic [wtosc_pkg::IDX_W-1:0]   out_idx_reg;

    logic [wtosc_pkg::MUL_A_W-1:0] mul_a;
    logic [wtosc_pkg::MUL_B_W-1:0] mul_b;
    logic [PW-1:0]                 prod;
    logic [wtosc_pkg::GMC_W-1:0]   gmc;
    logic [wtosc_pkg::ROWY_W-1:0]  rowy;
    logic [FW-1:0]                 f_sat;
    logic [SW-1:0]                 s_load;
    logic [PW-1:0]                 col_full, row_full;
    logic [wtosc_pkg::COL_W-1:0]   col_val;
    logic [wtosc_pkg::ROW_W-1:0]   row_val;
    logic                          out_load;

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = cw.wr_out && out_free;

    assign gmc = wtosc_pkg::GMC_W'(wtosc_pkg::GLIDE_SAMPLES) - {1'b0, cnt_reg};

    // (f - 320) / 64, the remaining /5 goes through the multiplier
    always_comb begin
        if (f_cur_reg < FW'(wtosc_pkg::FREQ_MIN)) begin
            rowy = '0;
        end else begin
            rowy = wtosc_pkg::ROWY_W'((f_cur_reg - FW'(wtosc_pkg::FREQ_MIN))
                                      >> wtosc_pkg::ROW_PRE_SHIFT);
        end
    end

    always_comb begin
        case (cw.a_sel)
            wtosc_pkg::A_F_OLD: mul_a = wtosc_pkg::MUL_A_W'(tgt_b_reg ? freq_a_reg : freq_b_reg);
            wtosc_pkg::A_F_TGT: mul_a = wtosc_pkg::MUL_A_W'(tgt_b_reg ? freq_b_reg : freq_a_reg);
            wtosc_pkg::A_S_OLD: mul_a = wtosc_pkg::MUL_A_W'(tgt_b_reg ? symm_a_reg : symm_b_reg);
            wtosc_pkg::A_S_TGT: mul_a = wtosc_pkg::MUL_A_W'(tgt_b_reg ? symm_b_reg : symm_a_reg);
            wtosc_pkg::A_PPH:   mul_a = pph_reg;
            wtosc_pkg::A_S_CUR: mul_a = wtosc_pkg::MUL_A_W'(s_cur_reg);
            wtosc_pkg::A_ROWY:  mul_a = wtosc_pkg::MUL_A_W'(rowy);
            default:            mul_a = '0;
        endcase
    end

    always_comb begin
        case (cw.b_sel)
            wtosc_pkg::B_GMC:       mul_b = wtosc_pkg::MUL_B_W'(gmc);
            wtosc_pkg::B_CNT:       mul_b = wtosc_pkg::MUL_B_W'(cnt_reg);
            wtosc_pkg::B_F_CUR:     mul_b = f_cur_reg;
            wtosc_pkg::B_COL_SCALE: mul_b = wtosc_pkg::MUL_B_W'(wtosc_pkg::COL_SCALE);
            wtosc_pkg::B_ROW_RECIP: mul_b = wtosc_pkg::MUL_B_W'(wtosc_pkg::ROW_RECIP);
            default:                mul_b = '0;
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    always_comb begin
        case (cw.acc_op)
            wtosc_pkg::ACC_LOAD: acc_next = prod;
            wtosc_pkg::ACC_ADD:  acc_next = acc_reg + prod;
            default:             acc_next = acc_reg;
        endcase
    end

    // clamps on the scaled results
    assign col_full = acc_reg >> wtosc_pkg::COL_SHIFT;
    assign row_full = acc_reg >> wtosc_pkg::ROW_SHIFT;
    assign col_val  = (col_full > PW'(wtosc_pkg::COL_MAX)) ?
                      wtosc_pkg::COL_W'(wtosc_pkg::COL_MAX) : col_full[wtosc_pkg::COL_W-1:0];
    assign row_val  = (row_full > PW'(wtosc_pkg::ROW_MAX)) ?
                      wtosc_pkg::ROW_W'(wtosc_pkg::ROW_MAX) : row_full[wtosc_pkg::ROW_W-1:0];

    // pair load operands
    always_comb begin
        if (nf_reg < FW'(wtosc_pkg::FREQ_MIN)) begin
            f_sat = FW'(wtosc_pkg::FREQ_MIN);
        end else if (nf_reg > FW'(wtosc_pkg::FREQ_MAX)) begin
            f_sat = FW'(wtosc_pkg::FREQ_MAX);
        end else begin
            f_sat = nf_reg;
        end
        if (mode_reg == wtosc_pkg::MODE_SET_FS) begin
            if (ns_reg < SW'(wtosc_pkg::SYMM_MIN)) begin
                s_load = SW'(wtosc_pkg::SYMM_MIN);
            end else if (ns_reg > SW'(wtosc_pkg::SYMM_MAX)) begin
                s_load = SW'(wtosc_pkg::SYMM_MAX);
            end else begin
                s_load = ns_reg;
            end
        end else begin
            s_load = tgt_b_reg ? symm_b_reg : symm_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_a_reg    <= FW'(wtosc_pkg::FREQ_RESET);
            freq_b_reg    <= FW'(wtosc_pkg::FREQ_RESET);
            symm_a_reg    <= SW'(wtosc_pkg::SYMM_RESET);
            symm_b_reg    <= SW'(wtosc_pkg::SYMM_RESET);
            tgt_b_reg     <= 1'b0;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            pph_reg       <= wtosc_pkg::PPH_W'(wtosc_pkg::PPH_RESET);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                pph_reg <= cfg_wdata;
            end
            if (cw.wr_phase) begin
                phase_reg <= phase_reg
                             + wtosc_pkg::PHASE_W'(acc_reg >> wtosc_pkg::HZ_SHIFT);
            end
            if (cw.load_pair) begin
                if (tgt_b_reg) begin
                    freq_a_reg <= f_sat;
                    symm_a_reg <= s_load;
                end else begin
                    freq_b_reg <= f_sat;
                    symm_b_reg <= s_load;
                end
                tgt_b_reg <= !tgt_b_reg;
                cnt_reg   <= '0;
            end else if (out_load && (cnt_reg != '1)) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (in_accept) begin
            mode_reg <= in_mode;
            nf_reg   <= in_freq;
            ns_reg   <= in_symm;
        end
        if (cw.wr_freq) begin
            f_cur_reg <= FW'(acc_reg >> CW);
        end
        if (cw.wr_symm) begin
            s_cur_reg <= SW'(acc_reg >> CW);
        end
        if (cw.wr_col) begin
            col_reg <= col_val;
        end
        if (out_load) begin
            out_row_reg <= row_val;
            out_col_reg <= col_reg;
            out_idx_reg <= phase_reg[wtosc_pkg::PHASE_W-1:wtosc_pkg::FRAC_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_idx   = out_idx_reg;

endmodule

// ===== hw/rtl/wavetable_oscillator_glide_addr.sv =====
// a sample tick runs the F_OLD..COL steps, then EMIT registers its result onto m_tvalid
// s_tready is high only in IDLE, so each tick or load ends before the next is taken
// commands run as a microcode program around the single 25x17 multiplier
// a pending result in the output register stalls only the last step of the next tick
// reset (aresetn low, synchronous) restores both pairs, glide, phase and phase_per_hz
module wavetable_oscillator_glide_addr (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // mode, new_frequency, new_symmetry
    input  logic [wtosc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pitch_row, symmetry_column, phase_index
    output logic [wtosc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [wtosc_pkg::PPH_W-1:0]       cfg_wdata
);

    localparam int MB = wtosc_pkg::MODE_W;
    localparam int FB = MB + wtosc_pkg::FREQ_W;
    localparam int SB = FB + wtosc_pkg::SYMM_W;

    wtosc_pkg::ucode_t      cw;
    wtosc_pkg::seq_status_t status;
    wtosc_pkg::mode_t       in_mode;
    logic                   in_ready;
    logic                   out_free;
    logic [wtosc_pkg::ROW_W-1:0] out_row;
    logic [wtosc_pkg::COL_W-1:0] out_col;
    logic [wtosc_pkg::IDX_W-1:0] out_idx;

    assign in_mode         = wtosc_pkg::mode_t'(s_tdata[MB-1:0]);
    assign status.in_valid = s_tvalid;
    assign status.mode     = in_mode;
    assign status.out_free = out_free;
    assign s_tready        = in_ready;

    wtosc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (status),
        .cw       (cw),
        .in_ready (in_ready)
    );

    wtosc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cw        (cw),
        .in_accept (s_tvalid && in_ready),
        .in_mode   (in_mode),
        .in_freq   (s_tdata[FB-1:MB]),
        .in_symm   (s_tdata[SB-1:FB]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_idx   (out_idx),
        .out_free  (out_free)
    );

    assign m_tdata = wtosc_pkg::M_TDATA_W'({out_idx, out_col, out_row});

endmodule

// ===== hw/rtl/wtosc_checker.sv =====
module wtosc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [wtosc_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [wtosc_pkg::M_TDATA_W-1:0]   m_tdata
);

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // a tick or a load keeps the engine busy for the next cycle
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready &&
        ((s_tdata[wtosc_pkg::MODE_W-1:0] == wtosc_pkg::MODE_TICK) ||
         (s_tdata[wtosc_pkg::MODE_W-1:0] == wtosc_pkg::MODE_SET_FS) ||
         (s_tdata[wtosc_pkg::MODE_W-1:0] == wtosc_pkg::MODE_SET_F)) |=> !s_tready)
        else $error("input taken again right after a command");

    // a new result is only produced from the final program step
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the engine was idle");

endmodule

bind wavetable_oscillator_glide_addr wtosc_checker u_wtosc_checker (.*);

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wtosc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int ROW_STEP   = 320;
    localparam int CHUNK_CMDS = 200;
    localparam int SETTLE_CYC = 20;

    typedef struct {
        logic [MODE_W-1:0] md;
        logic [FREQ_W-1:0] nf;
        logic [SYMM_W-1:0] ns;
    } osc_cmd_t;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [IDX_W-1:0] index;
    } osc_addr_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    wire                  s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    wire                  m_tvalid;
    logic                 m_tready  = 1'b0;
    wire  [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [PPH_W-1:0]     cfg_wdata = '0;

    osc_cmd_t  osc_cmds[$];
    osc_addr_t predicted_addrs[$];
    int        err_count = 0;

    // mirror of the oscillator state
    logic [FREQ_W-1:0]  freq_a    = FREQ_W'(FREQ_RESET);
    logic [FREQ_W-1:0]  freq_b    = FREQ_W'(FREQ_RESET);
    logic [SYMM_W-1:0]  symm_a    = SYMM_W'(SYMM_RESET);
    logic [SYMM_W-1:0]  symm_b    = SYMM_W'(SYMM_RESET);
    logic               target_b  = 1'b0;
    logic [CNT_W-1:0]   glide_cnt = '0;
    logic [PHASE_W-1:0] phase_acc = '0;
    logic [PPH_W-1:0]   pph_model = PPH_W'(PPH_RESET);

    int gap_left   = 0;
    int stall_left = 0;
    int tx_calm    = 0;
    int rx_calm    = 0;

    wavetable_oscillator_glide_addr i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_idle(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic longint unsigned glide_mix(longint unsigned from_v, longint unsigned to_v,
                                                  longint unsigned c);
        return (from_v * (GLIDE_SAMPLES - c) + to_v * c) / GLIDE_SAMPLES;
    endfunction

    task automatic track_cmd(logic [MODE_W-1:0] md, logic [FREQ_W-1:0] nf,
                             logic [SYMM_W-1:0] ns);
        longint unsigned fq, sy, f_cur, s_cur, step, row, col;
        osc_addr_t want;
        fq = (nf < FREQ_MIN) ? FREQ_MIN : (nf > FREQ_MAX) ? FREQ_MAX : nf;
        sy = (ns < SYMM_MIN) ? SYMM_MIN : (ns > SYMM_MAX) ? SYMM_MAX : ns;
        case (md)
            MODE_SET_FS, MODE_SET_F: begin
                if (md == MODE_SET_F) sy = target_b ? symm_b : symm_a;
                if (target_b) begin
                    freq_a = FREQ_W'(fq);
                    symm_a = SYMM_W'(sy);
                end else begin
                    freq_b = FREQ_W'(fq);
                    symm_b = SYMM_W'(sy);
                end
                target_b  = !target_b;
                glide_cnt = '0;
            end
            MODE_TICK: begin
                if (target_b) begin
                    f_cur = glide_mix(freq_a, freq_b, glide_cnt);
                    s_cur = glide_mix(symm_a, symm_b, glide_cnt);
                end else begin
                    f_cur = glide_mix(freq_b, freq_a, glide_cnt);
                    s_cur = glide_mix(symm_b, symm_a, glide_cnt);
                end
                step = pph_model;
                step = (step * f_cur) >> HZ_SHIFT;
                phase_acc = PHASE_W'(phase_acc + step);
                row = (f_cur < FREQ_MIN) ? 0 : (f_cur - FREQ_MIN) / ROW_STEP;
                if (row > ROW_MAX) row = ROW_MAX;
                col = (s_cur * COL_SCALE) >> COL_SHIFT;
                if (col > COL_MAX) col = COL_MAX;
                want.row    = row[ROW_W-1:0];
                want.column = col[COL_W-1:0];
                want.index  = phase_acc[PHASE_W-1:FRAC_W];
                predicted_addrs.push_back(want);
                if (glide_cnt < GLIDE_SAMPLES - 1) glide_cnt++;
            end
            default: ;
        endcase
    endtask

    // input side
    always @(posedge aclk) begin : drive_s
        osc_cmd_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_cmd(s_tdata[0 +: MODE_W], s_tdata[MODE_W +: FREQ_W],
                          s_tdata[MODE_W+FREQ_W +: SYMM_W]);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (osc_cmds.size() > 0) begin
                    nxt = osc_cmds.pop_front();
                    s_tdata  <= S_TDATA_W'({nxt.ns, nxt.nf, nxt.md});
                    s_tvalid <= 1'b1;
                    gap_left = pick_idle(tx_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin : watch_m
        osc_addr_t want;
        osc_addr_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.row    = m_tdata[0 +: ROW_W];
                got.column = m_tdata[ROW_W +: COL_W];
                got.index  = m_tdata[ROW_W+COL_W +: IDX_W];
                if (predicted_addrs.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected transfer, expected none, actual row %0d col %0d idx %0d",
                             $time, got.row, got.column, got.index);
                end else begin
                    want = predicted_addrs.pop_front();
                    if (got.row !== want.row) begin
                        err_count++;
                        $display("%0t: pitch_row expected %0d actual %0d",
                                 $time, want.row, got.row);
                    end
                    if (got.column !== want.column) begin
                        err_count++;
                        $display("%0t: symmetry_column expected %0d actual %0d",
                                 $time, want.column, got.column);
                    end
                    if (got.index !== want.index) begin
                        err_count++;
                        $display("%0t: phase_index expected %0d actual %0d",
                                 $time, want.index, got.index);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ((m_tvalid && m_tready) || $urandom_range(0, 7) == 0)
                    stall_left = pick_idle(rx_calm);
            end
        end
    end

    task automatic queue_cmd(logic [MODE_W-1:0] md, logic [FREQ_W-1:0] nf,
                             logic [SYMM_W-1:0] ns);
        osc_cmd_t c;
        c.md = md;
        c.nf = nf;
        c.ns = ns;
        osc_cmds.push_back(c);
    endtask

    function automatic logic [FREQ_W-1:0] rand_freq();
        case ($urandom_range(0, 9))
            0: return FREQ_W'($urandom_range(0, FREQ_MIN));
            1: return FREQ_W'($urandom_range(FREQ_MAX, (1 << FREQ_W) - 1));
            2: return FREQ_W'(FREQ_MIN);
            3: return FREQ_W'(FREQ_MAX);
            default: return FREQ_W'($urandom_range(FREQ_MIN, FREQ_MAX));
        endcase
    endfunction

    function automatic logic [SYMM_W-1:0] rand_symm();
        case ($urandom_range(0, 7))
            0: return SYMM_W'($urandom_range(0, SYMM_MIN));
            1: return SYMM_W'($urandom_range(SYMM_MAX, (1 << SYMM_W) - 1));
            default: return SYMM_W'($urandom_range(SYMM_MIN, SYMM_MAX));
        endcase
    endfunction

    // mostly a load followed by a run of ticks, some long enough to finish the glide
    task automatic queue_random(int n);
        int done;
        int run;
        logic [MODE_W-1:0] md;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 99) < 85) begin
                md = ($urandom_range(0, 2) == 0) ? MODE_SET_F : MODE_SET_FS;
                queue_cmd(md, rand_freq(), rand_symm());
                run = ($urandom_range(0, 99) < 5) ? $urandom_range(GLIDE_SAMPLES, GLIDE_SAMPLES + 20)
                                                  : $urandom_range(1, 24);
                repeat (run) queue_cmd(MODE_TICK, FREQ_W'($urandom()), SYMM_W'($urandom()));
                done += run + 1;
            end else begin
                md = MODE_W'($urandom_range(0, 3));
                queue_cmd(md, FREQ_W'($urandom()), SYMM_W'($urandom()));
                if (md != MODE_UNUSED) done++;
            end
        end
    endtask

    task automatic wait_drained();
        while (osc_cmds.size() != 0 || s_tvalid || predicted_addrs.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_pph(logic [PPH_W-1:0] v);
        wait_drained();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        pph_model = v;
    endtask

    initial begin : stimulus
        logic [PPH_W-1:0] pph_plan[5];
        pph_plan[0] = '0;
        pph_plan[1] = PPH_W'(1);
        pph_plan[2] = PPH_W'($urandom_range(1, 1 << FRAC_W));
        pph_plan[3] = PPH_W'($urandom_range(1, 1 << 20));
        pph_plan[4] = PPH_W'(PPH_RESET);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset state, saturation at both ends, frequency-only load, ignored fields
        queue_cmd(MODE_TICK, '0, '0);
        queue_cmd(MODE_TICK, '1, '1);
        queue_cmd(MODE_SET_FS, '0, '0);
        queue_cmd(MODE_TICK, '0, '0);
        queue_cmd(MODE_TICK, '0, '0);
        queue_cmd(MODE_SET_FS, '1, '1);
        queue_cmd(MODE_TICK, '0, '0);
        queue_cmd(MODE_SET_F, FREQ_W'(FREQ_MAX), '1);
        queue_cmd(MODE_TICK, '0, '0);
        queue_cmd(MODE_SET_F, FREQ_W'(FREQ_MIN - 1), '0);
        queue_cmd(MODE_TICK, '0, '0);
        queue_cmd(MODE_SET_FS, FREQ_W'(FREQ_MIN), SYMM_W'(SYMM_MIN));
        queue_cmd(MODE_TICK, '0, '0);
        queue_cmd(MODE_SET_FS, FREQ_W'(FREQ_MAX), SYMM_W'(SYMM_MAX));
        queue_cmd(MODE_TICK, '0, '0);
        queue_cmd(MODE_UNUSED, FREQ_W'($urandom()), SYMM_W'($urandom()));
        queue_cmd(MODE_TICK, '1, '1);

        // step of several table lengths per sample
        write_pph(PPH_W'(1 << FRAC_W));
        queue_cmd(MODE_SET_FS, FREQ_W'(FREQ_MAX), SYMM_W'(SYMM_MAX));
        queue_cmd(MODE_SET_FS, FREQ_W'(FREQ_MAX), SYMM_W'(SYMM_MAX));
        repeat (3) queue_cmd(MODE_TICK, '0, '0);
        queue_random(CHUNK_CMDS);

        foreach (pph_plan[i]) begin
            write_pph(pph_plan[i]);
            queue_random(CHUNK_CMDS);
        end

        wait_drained();
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/wtosc_pkg.sv
hw/rtl/wtosc_ucode_rom.sv
hw/rtl/wtosc_seq.sv
hw/rtl/wtosc_datapath.sv
hw/rtl/wavetable_oscillator_glide_addr.sv
hw/rtl/wtosc_checker.sv
sim/testbench.sv
